FILE: design/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants of the calendar date stepper
// Field widths, register indexes, controller states, the command and status
// structs between controller and datapath, and the calendar helper functions.
// ----------------------------------------------------------------------------
package cds_pkg;

    // Field widths
    localparam int DELTA_W    = 16;
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 16;
    localparam int WDAY_W     = 3;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int MOD25_W    = 5;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START_DAY     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_MONTH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_YEAR    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_WEEKDAY = 2'd3;

    // Item kinds
    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Calendar codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;
    localparam logic [WDAY_W-1:0]  WDAY_MON  = 3'd0;
    localparam logic [WDAY_W-1:0]  WDAY_SAT  = 3'd5;
    localparam logic [WDAY_W-1:0]  WDAY_SUN  = 3'd6;
    localparam logic [WDAY_W-1:0]  WDAY_BAD  = 3'd7;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_NONE  = 5'd0;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 16'hFFFF;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 16'h0000;
    localparam logic [YEAR_W-1:0]  YEAR_RST  = 16'd2000;

    // Year residue modulo 25, tracked beside the year
    localparam logic [MOD25_W-1:0] MOD25_MAX = 5'd24;
    // residue of year 65535 modulo 25
    localparam logic [MOD25_W-1:0] MOD25_OF_YEAR_MAX = 5'd10;

    // Year quotient by 25: floor(y / 25) = (y * 83887) >> 21 for any 16-bit year
    localparam int YQUO_W       = 12;
    localparam int MOD25_MUL_W  = 17;
    localparam int MOD25_PROD_W = YEAR_W + MOD25_MUL_W;
    localparam int MOD25_SHIFT  = 21;
    localparam logic [MOD25_MUL_W-1:0] MOD25_MUL = 17'd83887;
    localparam logic [YEAR_W-1:0]      MOD25_DIV = 16'd25;

    typedef struct packed {
        logic                      kind;
        logic signed [DELTA_W-1:0] delta;
    } t_in_item;

    typedef struct packed {
        logic [DAY_W-1:0]   out_day;
        logic [MONTH_W-1:0] out_month;
        logic [YEAR_W-1:0]  out_year;
        logic [WDAY_W-1:0]  out_weekday;
        logic               year_wrapped;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LMOD,
        ST_LFIN,
        ST_MOVE,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic mod_step;
        logic load_fin;
        logic day_step;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic in_load;
        logic mod_last;
        logic count_zero;
        logic out_free;
    } t_dp_sts;

    // Leap year from the low bits and the residue modulo 25
    function automatic logic is_leap(input logic [3:0] y_low,
                                     input logic [MOD25_W-1:0] y_mod25);
        logic div4;
        logic div16;
        logic div25;
        div4  = (y_low[1:0] == 2'b00);
        div16 = (y_low == 4'b0000);
        div25 = (y_mod25 == '0);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    // Length of a month in days
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

endpackage

FILE: design/cds_ctrl.sv
// ----------------------------------------------------------------------------
// cds_ctrl: controller of the calendar date stepper
// Sequences one transaction at a time: load (residue pass, then finish) or
// move (one day per cycle), then hands the result to the output register.
// ----------------------------------------------------------------------------
module cds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cds_pkg::t_dp_sts i_sts,
    output cds_pkg::t_dp_cmd o_cmd
);
    import cds_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_load ? ST_LMOD : ST_MOVE;
                end
            end
            ST_LMOD: begin
                if (i_sts.mod_last) begin
                    n_state = ST_LFIN;
                end
            end
            ST_LFIN: begin
                n_state = ST_PUSH;
            end
            ST_MOVE: begin
                if (i_sts.count_zero) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_LMOD: o_cmd.mod_step = 1'b1;
            ST_LFIN: o_cmd.load_fin = 1'b1;
            ST_MOVE: o_cmd.day_step = !i_sts.count_zero;
            ST_PUSH: o_cmd.push     = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: design/cds_datapath.sv
// ----------------------------------------------------------------------------
// cds_datapath: date registers and stepping logic of the calendar date stepper
// Holds the start registers, the current date with its year residue modulo
// 25, the day counter of a move and the output register.
// ----------------------------------------------------------------------------
module cds_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cds_pkg::t_in_item                  i_in,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output cds_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_we,
    input  logic [cds_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [cds_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  cds_pkg::t_dp_cmd                   i_cmd,
    output cds_pkg::t_dp_sts                   o_sts
);
    import cds_pkg::*;

    // Start registers
    logic [DAY_W-1:0]   r_start_day;
    logic [MONTH_W-1:0] r_start_month;
    logic [YEAR_W-1:0]  r_start_year;
    logic [WDAY_W-1:0]  r_start_wday;

    // Current date and move state
    logic [DAY_W-1:0]   r_day,   n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year,  n_year;
    logic [WDAY_W-1:0]  r_wday,  n_wday;
    logic [MOD25_W-1:0] r_ymod,  n_ymod;
    logic [DELTA_W-1:0] r_count, n_count;
    logic               r_back,  n_back;
    logic               r_wrap,  n_wrap;
    logic [YQUO_W-1:0]  r_yquo,  n_yquo;
    logic               r_mod_phase, n_mod_phase;

    // Output register
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic                    cur_leap;
    logic [DAY_W-1:0]        cur_len;
    logic [DAY_W-1:0]        prev_len;
    logic [MONTH_W-1:0]      prev_month;
    logic [DELTA_W-1:0]      in_mag;
    logic [MONTH_W-1:0]      load_month;
    logic [MOD25_PROD_W-1:0] year_prod;
    logic [YQUO_W-1:0]       year_quo;
    logic [YEAR_W-1:0]       year_rem;

    assign cur_leap   = is_leap(r_year[3:0], r_ymod);
    assign cur_len    = days_in(r_month, cur_leap);
    assign prev_month = (r_month == MONTH_JAN) ? MONTH_DEC : r_month - 4'd1;
    assign prev_len   = days_in(prev_month, cur_leap);
    assign in_mag     = i_in.delta[DELTA_W-1] ? (~i_in.delta + 1'b1) : i_in.delta;
    assign load_month = (r_start_month > MONTH_DEC) ? MONTH_DEC : r_start_month;

    // Year divided by 25 by reciprocal multiplication, remainder from the quotient
    assign year_prod  = MOD25_PROD_W'(r_year) * MOD25_PROD_W'(MOD25_MUL);
    assign year_quo   = year_prod[MOD25_SHIFT +: YQUO_W];
    assign year_rem   = r_year - YEAR_W'(r_yquo) * MOD25_DIV;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_day   <= DAY_FIRST;
            r_start_month <= MONTH_JAN;
            r_start_year  <= YEAR_RST;
            r_start_wday  <= WDAY_SAT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_DAY:     r_start_day   <= i_cfg_wdata[DAY_W-1:0];
                CFG_START_MONTH:   r_start_month <= i_cfg_wdata[MONTH_W-1:0];
                CFG_START_YEAR:    r_start_year  <= i_cfg_wdata[YEAR_W-1:0];
                CFG_START_WEEKDAY: r_start_wday  <= i_cfg_wdata[WDAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Next date state
    always_comb begin
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_wday      = r_wday;
        n_ymod      = r_ymod;
        n_count     = r_count;
        n_back      = r_back;
        n_wrap      = r_wrap;
        n_yquo      = r_yquo;
        n_mod_phase = r_mod_phase;

        if (i_cmd.accept) begin
            // Capture the transaction
            n_back      = i_in.delta[DELTA_W-1];
            n_count     = in_mag;
            n_wrap      = 1'b0;
            n_mod_phase = 1'b0;
            if (i_in.kind == KIND_LOAD) begin
                n_month = load_month;
                n_year  = r_start_year;
                n_ymod  = '0;
            end
        end else if (i_cmd.mod_step) begin
            // Take the quotient first, then the residue of the loaded year
            if (!r_mod_phase) begin
                n_yquo = year_quo;
            end else begin
                n_ymod = year_rem[MOD25_W-1:0];
            end
            n_mod_phase = !r_mod_phase;
        end else if (i_cmd.load_fin) begin
            // Clamp day into the loaded month, wrap weekday seven
            if (r_start_day == DAY_NONE) begin
                n_day = DAY_FIRST;
            end else if (r_start_day > cur_len) begin
                n_day = cur_len;
            end else begin
                n_day = r_start_day;
            end
            n_wday = (r_start_wday == WDAY_BAD) ? WDAY_MON : r_start_wday;
        end else if (i_cmd.day_step) begin
            n_count = r_count - 1'b1;
            if (!r_back) begin
                // Advance one day
                n_wday = (r_wday == WDAY_SUN) ? WDAY_MON : r_wday + 3'd1;
                if (r_day == cur_len) begin
                    n_day = DAY_FIRST;
                    if (r_month == MONTH_DEC) begin
                        n_month = MONTH_JAN;
                        n_year  = r_year + 16'd1;
                        if (r_year == YEAR_MAX) begin
                            n_wrap = 1'b1;
                            n_ymod = '0;
                        end else begin
                            n_ymod = (r_ymod == MOD25_MAX) ? '0 : r_ymod + 5'd1;
                        end
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end else begin
                    n_day = r_day + 5'd1;
                end
            end else begin
                // Go back one day
                n_wday = (r_wday == WDAY_MON) ? WDAY_SUN : r_wday - 3'd1;
                if (r_day == DAY_FIRST) begin
                    n_month = prev_month;
                    n_day   = prev_len;
                    if (r_month == MONTH_JAN) begin
                        n_year = r_year - 16'd1;
                        if (r_year == YEAR_MIN) begin
                            n_wrap = 1'b1;
                            n_ymod = MOD25_OF_YEAR_MAX;
                        end else begin
                            n_ymod = (r_ymod == '0) ? MOD25_MAX : r_ymod - 5'd1;
                        end
                    end
                end else begin
                    n_day = r_day - 5'd1;
                end
            end
        end
    end

    // Next output register
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (i_cmd.push) begin
            n_out.out_day      = r_day;
            n_out.out_month    = r_month;
            n_out.out_year     = r_year;
            n_out.out_weekday  = r_wday;
            n_out.year_wrapped = r_wrap;
            n_out_valid        = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= DAY_FIRST;
            r_month     <= MONTH_JAN;
            r_year      <= YEAR_RST;
            r_wday      <= WDAY_SAT;
            r_ymod      <= '0;
            r_count     <= '0;
            r_back      <= 1'b0;
            r_wrap      <= 1'b0;
            r_mod_phase <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_wday      <= n_wday;
            r_ymod      <= n_ymod;
            r_count     <= n_count;
            r_back      <= n_back;
            r_wrap      <= n_wrap;
            r_mod_phase <= n_mod_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_yquo <= n_yquo;
        r_out  <= n_out;
    end

    // Status to the controller
    always_comb begin
        o_sts.in_load    = (i_in.kind == KIND_LOAD);
        o_sts.mod_last   = r_mod_phase;
        o_sts.count_zero = (r_count == '0);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: design/calendar_date_stepper_top.sv
// A move steps the date one day per cycle and then pushes the result; a load
// runs the year residue step (quotient, then remainder), the finish step and the push.
// Only one transaction is in flight: a new input is accepted once the last result
// is pushed, and output stall holds the push.
// Reset (synchronous, active low): date 2000-01-01, Saturday; start registers
// to the same date; output register empty.
// ----------------------------------------------------------------------------
// calendar_date_stepper_top: Gregorian calendar day counter
// Keeps a date and weekday; a load copies the start date, a move steps the
// date by a signed number of days across month and year boundaries.
// ----------------------------------------------------------------------------
module calendar_date_stepper_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  cds_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output cds_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_we,
    input  logic [cds_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [cds_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import cds_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequence transactions
    cds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold and step the date
    cds_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

FILE: tb/sv/calendar_date_stepper_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_stepper_checker: date predictor and result scoreboard
// Watches the register port and both channels of the calendar date stepper.
// It keeps its own copy of the start registers and of the current date,
// predicts one date per accepted input transaction and compares each
// accepted output transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_date_stepper_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  cds_pkg::t_in_item              i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  cds_pkg::t_out_item             i_out,
    input  logic                           i_cfg_we,
    input  logic [cds_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [cds_pkg::CFG_W-1:0]      i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import cds_pkg::*;

    // Shadow start registers
    int start_day;
    int start_month;
    int start_year;
    int start_wday;

    // Shadow calendar state
    int cur_day;
    int cur_month;
    int cur_year;
    int cur_wday;

    t_out_item expected_dates[$];
    int        mismatches;
    int        compared;

    // Month length under the 4/100/400 leap rule
    function automatic int month_days(input int m, input int y);
        int len;
        case (m)
            1:          len = (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
            3, 5, 8, 10: len = 30;
            default:    len = 31;
        endcase
        return len;
    endfunction

    // Apply one transaction to the shadow date and return the expected result
    task automatic advance_calendar(input t_in_item item, output t_out_item res);
        int  n;
        int  len;
        int  rest;
        bit  back;
        bit  wrapped;
        wrapped = 1'b0;
        if (item.kind == KIND_LOAD) begin
            cur_month = (start_month > int'(MONTH_DEC)) ? int'(MONTH_DEC) : start_month;
            cur_year  = start_year;
            len       = month_days(cur_month, cur_year);
            cur_day   = (start_day == 0) ? 1 : start_day;
            if (cur_day > len)
                cur_day = len;
            cur_wday  = start_wday % 7;
        end else begin
            back = item.delta[DELTA_W-1];
            n    = back ? -int'(item.delta) : int'(item.delta);
            // Walk whole months first, then finish inside the last one
            while (n > 0) begin
                len = month_days(cur_month, cur_year);
                if (!back) begin
                    rest = len - cur_day + 1;
                    if (n >= rest) begin
                        n        -= rest;
                        cur_wday  = (cur_wday + rest) % 7;
                        cur_day   = 1;
                        if (cur_month == int'(MONTH_DEC)) begin
                            cur_month = int'(MONTH_JAN);
                            if (cur_year == int'(YEAR_MAX))
                                wrapped = 1'b1;
                            cur_year = (cur_year + 1) % 65536;
                        end else begin
                            cur_month++;
                        end
                    end else begin
                        cur_day  += n;
                        cur_wday  = (cur_wday + n) % 7;
                        n         = 0;
                    end
                end else begin
                    rest = cur_day;
                    if (n >= rest) begin
                        n        -= rest;
                        cur_wday  = (cur_wday + 7 - rest % 7) % 7;
                        if (cur_month == int'(MONTH_JAN)) begin
                            cur_month = int'(MONTH_DEC);
                            if (cur_year == int'(YEAR_MIN))
                                wrapped = 1'b1;
                            cur_year = (cur_year + 65535) % 65536;
                        end else begin
                            cur_month--;
                        end
                        cur_day = month_days(cur_month, cur_year);
                    end else begin
                        cur_day  -= n;
                        cur_wday  = (cur_wday + 7 - n % 7) % 7;
                        n         = 0;
                    end
                end
            end
        end
        res.out_day      = cur_day[DAY_W-1:0];
        res.out_month    = cur_month[MONTH_W-1:0];
        res.out_year     = cur_year[YEAR_W-1:0];
        res.out_weekday  = cur_wday[WDAY_W-1:0];
        res.year_wrapped = wrapped;
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] got_val);
        $display("%0t ns: mismatch on %s: expected %0d, actual %0d",
                 $time, name, exp_val, got_val);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item predicted;
        t_out_item oldest;
        if (!i_rst_n) begin
            // Reset: shadow registers and date return to 2000-01-01, Saturday
            start_day   = int'(DAY_FIRST);
            start_month = int'(MONTH_JAN);
            start_year  = int'(YEAR_RST);
            start_wday  = int'(WDAY_SAT);
            cur_day     = int'(DAY_FIRST);
            cur_month   = int'(MONTH_JAN);
            cur_year    = int'(YEAR_RST);
            cur_wday    = int'(WDAY_SAT);
            expected_dates.delete();
            mismatches  = 0;
            compared    = 0;
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_START_DAY:     start_day   = int'(i_cfg_wdata[DAY_W-1:0]);
                    CFG_START_MONTH:   start_month = int'(i_cfg_wdata[MONTH_W-1:0]);
                    CFG_START_YEAR:    start_year  = int'(i_cfg_wdata[YEAR_W-1:0]);
                    CFG_START_WEEKDAY: start_wday  = int'(i_cfg_wdata[WDAY_W-1:0]);
                    default: ;
                endcase
            end
            // Predict on each accepted input transaction
            if (i_in_valid && !i_in_stall) begin
                advance_calendar(i_in, predicted);
                expected_dates.push_back(predicted);
            end
            // Compare each accepted output transaction with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none, %s %0d-%0d-%0d wd %0d wrap %0d",
                             $time, "actual", i_out.out_year, i_out.out_month, i_out.out_day,
                             i_out.out_weekday, i_out.year_wrapped);
                    mismatches++;
                end else begin
                    oldest = expected_dates.pop_front();
                    compared++;
                    if (i_out.out_day !== oldest.out_day)
                        report_field("out_day", 32'(oldest.out_day), 32'(i_out.out_day));
                    if (i_out.out_month !== oldest.out_month)
                        report_field("out_month", 32'(oldest.out_month),
                                     32'(i_out.out_month));
                    if (i_out.out_year !== oldest.out_year)
                        report_field("out_year", 32'(oldest.out_year), 32'(i_out.out_year));
                    if (i_out.out_weekday !== oldest.out_weekday)
                        report_field("out_weekday", 32'(oldest.out_weekday),
                                     32'(i_out.out_weekday));
                    if (i_out.year_wrapped !== oldest.year_wrapped)
                        report_field("year_wrapped", 32'(oldest.year_wrapped),
                                     32'(i_out.year_wrapped));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_dates.size();
        o_checked    <= compared;
    end

endmodule

FILE: tb/sv/tb_calendar_date_stepper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_stepper_top: stimulus and verdict for the date stepper
// Drives loads and signed day moves through the input channel with random
// gaps and output back-pressure, reprograms the start registers between
// phases and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_calendar_date_stepper_top;
    import cds_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_LIMIT      = 150000;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 15;
    localparam int DRAIN_CYCLES    = 40;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_START_DAY;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int fail_count;
    int pending;
    int checked;
    int idle_cycles = 0;
    int hold_reqs   = 0;
    bit calm        = 1'b0;
    int n_loads     = 0;
    int n_moves     = 0;
    int n_phases    = 0;

    calendar_date_stepper_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    calendar_date_stepper_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 50 MHz clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles without any transaction
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog: end the run when the block stops moving
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: random stall runs, plus a long hold-off on request
    initial begin
        int run_left;
        int hold_left;
        int hold_seen;
        bit stall_now;
        run_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (calm || !rst_n) begin
                out_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    stall_now = ($urandom_range(0, 2) == 0);
                    if (stall_now)
                        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                               : $urandom_range(1, 3);
                    else
                        run_left = $urandom_range(1, 8);
                end
                run_left--;
                out_stall <= stall_now;
            end
        end
    end

    // Input gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Day count: mostly short moves, some longer, a few over the full range
    function automatic logic signed [DELTA_W-1:0] pick_delta();
        int                        r;
        int                        mag;
        logic signed [DELTA_W-1:0] d;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            d = DELTA_W'($urandom);
            return d;
        end
        if (r < 60)
            mag = $urandom_range(0, 40);
        else if (r < 88)
            mag = $urandom_range(0, 800);
        else
            mag = $urandom_range(0, 5000);
        d = DELTA_W'($urandom_range(0, 1) ? -mag : mag);
        return d;
    endfunction

    // Offer one input transaction and hold it until accepted
    task automatic send_item(input logic kind, input logic signed [DELTA_W-1:0] delta);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_item.kind   <= kind;
        in_item.delta  <= delta;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (kind == KIND_LOAD)
            n_loads++;
        else
            n_moves++;
    endtask

    // Drop valid and wait until every predicted date has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One register write; spare high bits of the data are random
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value,
                             input int width);
        logic [CFG_W-1:0] mask;
        logic [CFG_W-1:0] data;
        mask      = (width >= CFG_W) ? '1 : CFG_W'((1 << width) - 1);
        data      = CFG_W'($urandom);
        data      = (data & ~mask) | (CFG_W'(value) & mask);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Program all start registers once the block is idle
    task automatic program_start(input int day, input int month, input int year,
                                 input int wday);
        drain();
        write_reg(CFG_START_DAY, day, DAY_W);
        write_reg(CFG_START_MONTH, month, MONTH_W);
        write_reg(CFG_START_YEAR, year, YEAR_W);
        write_reg(CFG_START_WEEKDAY, wday, WDAY_W);
        cfg_we <= 1'b0;
        n_phases++;
    endtask

    // Main stimulus
    initial begin
        int   day;
        int   month;
        int   year;
        int   wday;
        logic kind;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Zero, unit and extreme moves from the reset date
        send_item(KIND_MOVE, 16'sd0);
        send_item(KIND_MOVE, 16'sd1);
        send_item(KIND_MOVE, -16'sd1);
        send_item(KIND_MOVE, 16'sh8000);
        send_item(KIND_MOVE, 16'sh7FFF);
        // Load with the reset start registers
        send_item(KIND_LOAD, 16'shFFFF);

        // Day past the end of February in a century year, weekday seven
        program_start(31, int'(MONTH_FEB), 1900, int'(WDAY_BAD));
        send_item(KIND_LOAD, 16'sd0);
        send_item(KIND_MOVE, 16'sd1);
        send_item(KIND_MOVE, -16'sd1);

        // Leap February, day clamps to 29
        program_start(30, int'(MONTH_FEB), 2000, int'(WDAY_SUN));
        send_item(KIND_LOAD, 16'sd5);
        send_item(KIND_MOVE, -16'sd60);

        // Day zero, month above December, top year: forward and back across the wrap
        program_start(int'(DAY_NONE), 15, int'(YEAR_MAX), int'(WDAY_MON));
        send_item(KIND_LOAD, 16'sd0);
        send_item(KIND_MOVE, 16'sd30);
        send_item(KIND_MOVE, 16'sd1);
        send_item(KIND_MOVE, -16'sd1);
        send_item(KIND_MOVE, 16'sd400);

        // First day of year zero, step back over the wrap
        program_start(int'(DAY_FIRST), int'(MONTH_JAN), int'(YEAR_MIN), int'(WDAY_SAT));
        send_item(KIND_LOAD, 16'sd0);
        send_item(KIND_MOVE, -16'sd1);
        send_item(KIND_MOVE, -16'sd1000);

        // April 31 clamps to 30; 2100 is not a leap year
        program_start(31, 3, 2100, 3);
        send_item(KIND_LOAD, 16'sd0);
        send_item(KIND_MOVE, -16'sd61);
        send_item(KIND_MOVE, 16'sd1);

        // 2400 is a leap year
        program_start(28, int'(MONTH_FEB), 2400, 2);
        send_item(KIND_LOAD, 16'sd0);
        send_item(KIND_MOVE, 16'sd1);
        send_item(KIND_MOVE, 16'sd1);

        // Random phases, each with its own start registers
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       day = int'(DAY_NONE);
                1:       day = 31;
                2:       day = $urandom_range(28, 31);
                default: day = $urandom_range(1, 31);
            endcase
            case ($urandom_range(0, 3))
                0:       year = int'(YEAR_MAX) - $urandom_range(0, 2);
                1:       year = $urandom_range(0, 2);
                2:       year = 100 * $urandom_range(0, 655);
                default: year = $urandom_range(0, 65535);
            endcase
            month = $urandom_range(0, 15);
            wday  = $urandom_range(0, 7);
            program_start(day, month, year, wday);
            calm <= (ph == 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Long output hold-off while input keeps coming
                if (ph == 1 && i == 4)
                    hold_reqs <= hold_reqs + 1;
                // Pause input until every result is back
                if (ph == 3 && i == 10)
                    drain();
                kind = ($urandom_range(0, 99) < 15) ? KIND_LOAD : KIND_MOVE;
                send_item(kind, pick_delta());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d moves and %0d loads over %0d start settings,",
                 n_moves, n_loads, n_phases);
        $display("with %0d results compared and %0d left waiting.", checked, pending);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
